// ----- sv/imd_pkg.sv -----
// Shared constants for the integer matrix determinant block.
package imd_pkg;
  localparam int ElemW = 16;
  localparam int DetW  = 32;
  localparam int CfgW  = 4;
  localparam int ApbW  = 32;
  localparam int AddrW = 3;
  localparam logic [AddrW-1:0] RegMatrixSize = AddrW'(0);
  localparam logic [CfgW-1:0]  SizeReset     = CfgW'(2);
endpackage

// ----- sv/imd_front.sv -----
// Front end: size register, element counter and matrix store write port.
module imd_front #(
  parameter int MAX_DIM = 8,
  parameter int DimW    = $clog2(MAX_DIM + 1),
  parameter int SAddrW  = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [imd_pkg::CfgW-1:0]   cfg_data_i,
  output logic [imd_pkg::CfgW-1:0]   size_o,
  input  logic                       acc_i,
  input  logic [imd_pkg::ElemW-1:0]  elem_i,
  output logic                       st_we_o,
  output logic [SAddrW-1:0]          st_addr_o,
  output logic [imd_pkg::ElemW-1:0]  st_data_o,
  output logic                       push_o,
  output logic [DimW-1:0]            push_n_o
);
  import imd_pkg::*;

  localparam int CntW = $clog2(MAX_DIM * MAX_DIM + 1);

  logic [CfgW-1:0] size_q, size_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DimW-1:0] n;
  logic [CntW-1:0] total, cnt_nxt;

  always_comb begin
    if (size_q == '0) n = DimW'(1);
    else if (32'(size_q) > MAX_DIM) n = DimW'(MAX_DIM);
    else n = DimW'(size_q);
  end

  assign total   = CntW'(n * n);
  assign cnt_nxt = cnt_q + CntW'(1);

  always_comb begin
    size_d = size_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      size_d = cfg_data_i;
      cnt_d  = '0;
    end else if (acc_i) begin
      cnt_d = (cnt_nxt >= total) ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      cnt_q  <= '0;
    end else begin
      size_q <= size_d;
      cnt_q  <= cnt_d;
    end
  end

  assign size_o    = size_q;
  assign st_we_o   = acc_i;
  assign st_addr_o = cnt_q[SAddrW-1:0];
  assign st_data_o = elem_i;
  assign push_o    = acc_i && (cnt_nxt >= total);
  assign push_n_o  = n;
endmodule

// ----- sv/imd_queue.sv -----
// Two-entry job queue carrying the matrix size from front to back.
module imd_queue #(
  parameter int DimW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [DimW-1:0] push_n_i,
  input  logic            pop_i,
  output logic [DimW-1:0] head_o,
  output logic            empty_o
);
  logic [DimW-1:0] ent_q [2];
  logic [1:0]      cnt_q;
  logic            rd_q, wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= push_n_i;
  end

  assign head_o  = ent_q[rd_q];
  assign empty_o = (cnt_q == '0);
endmodule

// ----- sv/imd_back.sv -----
// Back end: matrix store and subset-minor expansion with a shared multiplier.
module imd_back #(
  parameter int MAX_DIM = 8,
  parameter int DimW    = $clog2(MAX_DIM + 1),
  parameter int SAddrW  = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      st_we_i,
  input  logic [SAddrW-1:0]         st_addr_i,
  input  logic [imd_pkg::ElemW-1:0] st_data_i,
  input  logic                      job_valid_i,
  input  logic [DimW-1:0]           job_n_i,
  output logic                      pop_o,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [imd_pkg::DetW-1:0]  out_data_o
);
  import imd_pkg::*;

  localparam int ColW  = $clog2(MAX_DIM);
  localparam int Masks = 2 ** MAX_DIM;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StAcc  = 3'd3;
  localparam logic [2:0] StSave = 3'd4;

  logic [ElemW-1:0]   store [MAX_DIM*MAX_DIM];
  logic [DetW-1:0]    dmem  [Masks];

  logic [2:0]         state_q;
  logic [DimW-1:0]    n_q;
  logic [MAX_DIM-1:0] mask_q, full;
  logic [ColW-1:0]    c_q;
  logic               pos_q, sub_zero_q;
  logic [DetW-1:0]    acc_q, prod_q, dval_q;
  logic [ElemW-1:0]   aval_q;
  logic               ovld_q;
  logic [DetW-1:0]    odata_q;

  logic [MAX_DIM-1:0] bit_c, sub;
  logic [ColW-1:0]    row;
  logic [SAddrW-1:0]  raddr;
  logic               last_c, done_mask, can_out, emit;
  logic [DetW-1:0]    a_ext, d_sel;

  assign full      = MAX_DIM'((1 << n_q) - 1);
  assign bit_c     = MAX_DIM'(1) << c_q;
  assign sub       = mask_q & ~bit_c;
  assign row       = ColW'(32'(n_q) - $countones(mask_q));
  assign raddr     = SAddrW'(32'(row) * 32'(n_q) + 32'(c_q));
  assign last_c    = (32'(c_q) == 32'(n_q) - 1);
  assign a_ext     = {{(DetW-ElemW){aval_q[ElemW-1]}}, aval_q};
  assign d_sel     = sub_zero_q ? DetW'(1) : dval_q;
  assign done_mask = (mask_q == full);
  assign can_out   = !ovld_q || out_ready_i;
  assign emit      = (state_q == StSave) && done_mask && can_out;
  assign pop_o     = (state_q == StIdle) && job_valid_i;
  assign busy_o    = (state_q != StIdle);

  always_ff @(posedge clk_i) begin
    if (st_we_i) store[st_addr_i] <= st_data_i;
    if (state_q == StScan) begin
      aval_q     <= store[raddr];
      dval_q     <= dmem[sub];
      sub_zero_q <= (sub == '0);
    end
    if (state_q == StMul) prod_q <= DetW'(a_ext * d_sel);
    if (state_q == StSave) dmem[mask_q] <= acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      n_q     <= DimW'(1);
      mask_q  <= '0;
      c_q     <= '0;
      pos_q   <= 1'b0;
      acc_q   <= '0;
      ovld_q  <= 1'b0;
      odata_q <= '0;
    end else begin
      if (ovld_q && out_ready_i && !emit) ovld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            n_q     <= job_n_i;
            mask_q  <= MAX_DIM'(1);
            c_q     <= '0;
            pos_q   <= 1'b0;
            acc_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (mask_q[c_q]) state_q <= StMul;
          else if (last_c) state_q <= StSave;
          else c_q <= c_q + ColW'(1);
        end
        StMul: state_q <= StAcc;
        StAcc: begin
          acc_q <= pos_q ? acc_q - prod_q : acc_q + prod_q;
          pos_q <= !pos_q;
          if (last_c) state_q <= StSave;
          else begin
            c_q     <= c_q + ColW'(1);
            state_q <= StScan;
          end
        end
        StSave: begin
          if (done_mask) begin
            if (can_out) begin
              ovld_q  <= 1'b1;
              odata_q <= acc_q;
              state_q <= StIdle;
            end
          end else begin
            mask_q  <= mask_q + MAX_DIM'(1);
            c_q     <= '0;
            pos_q   <= 1'b0;
            acc_q   <= '0;
            state_q <= StScan;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we_i |-> state_q == StIdle) else $error("store written during expansion");
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> mask_q <= full) else $error("mask beyond matrix");
  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> mask_q != '0) else $error("empty column set");
  a_result_after_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q) == StSave) else $error("stray result");
endmodule

// ----- sv/integer_matrix_determinant.sv -----
// Top level: streaming integer matrix determinant with APB size register.
// Expansion: each column term passes the scan, multiply and accumulate states, a skipped
// column only the scan state, and each of the 2**n - 1 column subsets ends in a save state.
// Throughput: one matrix per load of n*n words plus the expansion; set by the single
// shared 32x32 multiplier. Next matrix loads while a result waits.
// Reset: asynchronous active low; size register returns to 2, count to zero.
module integer_matrix_determinant #(
  parameter int MAX_DIM = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [15:0] element
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // [31:0] det_value
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [imd_pkg::AddrW-1:0]  paddr,
  input  logic [imd_pkg::ApbW-1:0]   pwdata,
  output logic [imd_pkg::ApbW-1:0]   prdata,
  output logic                       pready
);
  import imd_pkg::*;

  localparam int DimW   = $clog2(MAX_DIM + 1);
  localparam int SAddrW = $clog2(MAX_DIM * MAX_DIM);

  logic              cfg_we, acc, st_we, push, pop, q_empty, busy;
  logic [CfgW-1:0]   size;
  logic [SAddrW-1:0] st_addr;
  logic [ElemW-1:0]  st_data;
  logic [DimW-1:0]   push_n, head_n;

  assign pready        = 1'b1;
  assign cfg_we        = psel && penable && pwrite && (paddr == RegMatrixSize);
  assign prdata        = (paddr == RegMatrixSize) ? ApbW'(size) : '0;
  assign s_axis_tready = q_empty && !busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  imd_front #(.MAX_DIM(MAX_DIM), .DimW(DimW), .SAddrW(SAddrW)) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_data_i(pwdata[CfgW-1:0]), .size_o(size),
    .acc_i(acc), .elem_i(s_axis_tdata),
    .st_we_o(st_we), .st_addr_o(st_addr), .st_data_o(st_data),
    .push_o(push), .push_n_o(push_n)
  );

  imd_queue #(.DimW(DimW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_n_i(push_n),
    .pop_i(pop), .head_o(head_n), .empty_o(q_empty)
  );

  imd_back #(.MAX_DIM(MAX_DIM), .DimW(DimW), .SAddrW(SAddrW)) u_back (
    .clk_i, .rst_ni,
    .st_we_i(st_we), .st_addr_i(st_addr), .st_data_i(st_data),
    .job_valid_i(!q_empty), .job_n_i(head_n), .pop_o(pop), .busy_o(busy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata)
  );
endmodule

// ----- bench/tb_integer_matrix_determinant.sv -----
// Testbench for the streaming integer matrix determinant with its APB size register.
`timescale 1ns / 1ps

module tb_integer_matrix_determinant;
  import imd_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // [15:0] element
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [31:0] det_value
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [ApbW-1:0]   pwdata = '0;
  logic [ApbW-1:0]   prdata;
  logic              pready;

  integer_matrix_determinant #(.MAX_DIM(8)) dut (.*);

  localparam int MaxDim = 8;
  localparam int DrainCycles = 2500;

  logic signed [15:0] mat_elems [MaxDim*MaxDim];
  logic [3:0]         size_reg;
  int                 loaded;
  logic [31:0]        det_queue [$];
  int                 n_errors;
  bit                 rx_stall_on = 1'b1;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #400ms;
    $display("tb_integer_matrix_determinant: errors");
    $finish;
  end

  function automatic int dim_in_use();
    if (size_reg == 0) return 1;
    if (size_reg > MaxDim) return MaxDim;
    return int'(size_reg);
  endfunction

  // cofactor expansion on rows row..n-1 over the columns set in cols, mod 2**32
  function automatic logic [31:0] cofactor_det(int row, logic [7:0] cols, int n);
    logic [31:0] acc, term, a;
    int          pos;
    acc = '0;
    pos = 0;
    for (int c = 0; c < n; c++) begin
      if (cols[c]) begin
        a = 32'(mat_elems[row*n+c]);
        if (row + 1 >= n) return a;
        term = a * cofactor_det(row + 1, cols & ~(8'd1 << c), n);
        if (pos[0]) acc = acc - term;
        else acc = acc + term;
        pos++;
      end
    end
    return acc;
  endfunction

  // valid stays high after the accepting edge until the next falling edge
  task automatic send_element(logic signed [15:0] e);
    int n, w;
    w = $urandom_range(0, 4);
    @(negedge clk_i);
    if (w != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    s_axis_tdata  <= e;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n = dim_in_use();
    mat_elems[loaded] = e;
    loaded++;
    if (loaded >= n*n) begin
      det_queue.push_back(cofactor_det(0, 8'((1 << n) - 1), n));
      loaded = 0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (det_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_size(logic [ApbW-1:0] v, logic [AddrW-1:0] a = RegMatrixSize);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == RegMatrixSize) begin
      size_reg = v[3:0];
      loaded = 0;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (det_queue.size() == 0) begin
        $display("%0t: unexpected det word %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        if (det_queue[0] !== m_axis_tdata) begin
          $display("%0t: det mismatch expected %h actual %h", $time, det_queue[0],
                   m_axis_tdata);
          n_errors++;
        end
        void'(det_queue.pop_front());
      end
    end
  end

  // per word: while rx_stall_on is set, ready may first be held low; then high until a word is taken
  initial begin
    int w;
    @(negedge clk_i);
    forever begin
      w = rx_stall_on ? int'($urandom_range(0, 4)) : 0;
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  task automatic test_directed();
    logic signed [15:0] ext [4] = '{16'sh7fff, -16'sh8000, 16'sh5555, -16'sh5556};
    // size 2 from reset, extremes
    for (int i = 0; i < 4; i++) send_element(ext[i]);
    for (int i = 0; i < 4; i++) send_element(-16'sh8000);
    write_size(0);  // treated as size 1
    send_element(16'sh7fff);
    send_element(-16'sh8000);
    write_size(15); // clamped to 8, partial load dropped afterwards
    for (int i = 0; i < 5; i++) send_element(16'(i));
    write_size(1, AddrW'(4)); // unused address: no effect
    write_size(3);
    for (int i = 0; i < 9; i++) send_element(ext[i % 4]);
  endtask

  task automatic test_random_sizes();
    int n, mode;
    for (int sz = 1; sz <= MaxDim; sz++) begin
      write_size(sz);
      n = sz * sz;
      for (int k = 0; k < ((sz <= 4) ? 10 : 4) * n; k++) begin
        mode = $urandom_range(0, 3);
        if (mode == 0) send_element(16'($urandom));
        else if (mode == 1) send_element($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000);
        else send_element(16'($signed($urandom_range(0, 8)) - 4));
      end
    end
  endtask

  task automatic test_no_stall();
    rx_stall_on = 1'b0;
    write_size(2);
    repeat (200) send_element(16'($urandom));
    rx_stall_on = 1'b1;
    write_size(4);
    repeat (160) send_element(16'($urandom));
  endtask

  initial begin
    n_errors = 0;
    size_reg = SizeReset;
    loaded = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_sizes();
    test_no_stall();
    wait_idle();
    if (n_errors == 0) $display("tb_integer_matrix_determinant: clean");
    else $display("tb_integer_matrix_determinant: errors");
    $finish;
  end
endmodule
